// File: rtl/core/avr_dec_pkg.sv
package avr_dec_pkg;

    localparam int InstrWidth  = 16;
    localparam int RegIdxWidth = 5;
    localparam int ImmWidth    = 8;
    localparam int JumpWidth   = 16;

    // Operation class codes as they appear on the result bus.
    typedef enum logic [3:0] {
        CLS_UNKNOWN = 4'd0,
        CLS_NOP     = 4'd1,
        CLS_ADD     = 4'd2,
        CLS_ADC     = 4'd3,
        CLS_MOV     = 4'd4,
        CLS_CPI     = 4'd5,
        CLS_ADIW    = 4'd6,
        CLS_BREAK   = 4'd7,
        CLS_RET     = 4'd8,
        CLS_POP     = 4'd9,
        CLS_PUSH    = 4'd10,
        CLS_CALL    = 4'd11,
        CLS_RJMP    = 4'd12,
        CLS_LDI     = 4'd13,
        CLS_BREQ    = 4'd14,
        CLS_BRNE    = 4'd15
    } op_class_t;

    // Opcode group in bits 15:12 of the instruction word.
    localparam logic [3:0] GRP_ADD  = 4'h0;
    localparam logic [3:0] GRP_ADC  = 4'h1;
    localparam logic [3:0] GRP_MOV  = 4'h2;
    localparam logic [3:0] GRP_CPI  = 4'h3;
    localparam logic [3:0] GRP_MISC = 4'h9;
    localparam logic [3:0] GRP_RJMP = 4'hC;
    localparam logic [3:0] GRP_LDI  = 4'hE;
    localparam logic [3:0] GRP_BRCH = 4'hF;

    // Bit patterns inside the opcode groups.
    localparam logic [1:0] SEL_REG_PAIR = 2'b11;
    localparam logic [1:0] SEL_BREQ     = 2'b00;
    localparam logic [1:0] SEL_BRNE     = 2'b01;
    localparam logic [2:0] BRANCH_TAIL  = 3'b001;

    localparam logic [3:0]  ADIW_SUB   = 4'b0110;
    localparam logic [15:0] WORD_NOP   = 16'h0000;
    localparam logic [15:0] WORD_BREAK = 16'h9598;
    localparam logic [15:0] WORD_RET   = 16'h9508;
    localparam logic [15:0] MASK_STACK = 16'hFE0F;
    localparam logic [15:0] PAT_POP    = 16'h900F;
    localparam logic [15:0] PAT_PUSH   = 16'h920F;
    localparam logic [15:0] MASK_CALL  = 16'hFE0E;
    localparam logic [15:0] PAT_CALL   = 16'h940E;

    typedef struct packed {
        logic [JumpWidth-1:0]   jump_field;
        logic [ImmWidth-1:0]    imm_value;
        logic [RegIdxWidth-1:0] src_reg;
        logic [RegIdxWidth-1:0] dest_reg;
        op_class_t              op_class;
    } dec_result_t;

endpackage

// File: rtl/core/avr_dec_decode.sv
module avr_dec_decode
    import avr_dec_pkg::*;
(
    input  logic [InstrWidth-1:0] instr_word,
    input  logic [InstrWidth-1:0] next_word,
    output dec_result_t           result
);

    logic [RegIdxWidth-1:0] rd5;
    logic [RegIdxWidth-1:0] rr5;
    logic [ImmWidth-1:0]    k8;
    logic [RegIdxWidth-1:0] rd_upper;

    assign rd5      = {instr_word[8], instr_word[7:4]};
    assign rr5      = {instr_word[9], instr_word[3:0]};
    assign k8       = {instr_word[11:8], instr_word[3:0]};
    assign rd_upper = {1'b1, instr_word[7:4]};

    always_comb begin
        result = '0;
        unique case (instr_word[15:12])
            GRP_ADD: begin
                if (instr_word == WORD_NOP) begin
                    result.op_class = CLS_NOP;
                end else if (instr_word[11:10] == SEL_REG_PAIR) begin
                    result.op_class = CLS_ADD;
                    result.dest_reg = rd5;
                    result.src_reg  = rr5;
                end
            end
            GRP_ADC: begin
                if (instr_word[11:10] == SEL_REG_PAIR) begin
                    result.op_class = CLS_ADC;
                    result.dest_reg = rd5;
                    result.src_reg  = rr5;
                end
            end
            GRP_MOV: begin
                if (instr_word[11:10] == SEL_REG_PAIR) begin
                    result.op_class = CLS_MOV;
                    result.dest_reg = rd5;
                    result.src_reg  = rr5;
                end
            end
            GRP_CPI: begin
                result.op_class  = CLS_CPI;
                result.dest_reg  = rd_upper;
                result.imm_value = k8;
            end
            GRP_MISC: begin
                if (instr_word[11:8] == ADIW_SUB) begin
                    // Register pairs R24, R26, R28 and R30 only.
                    result.op_class  = CLS_ADIW;
                    result.dest_reg  = {2'b11, instr_word[5:4], 1'b0};
                    result.imm_value = {2'b00, instr_word[7:6], instr_word[3:0]};
                end else if (instr_word == WORD_BREAK) begin
                    result.op_class = CLS_BREAK;
                end else if (instr_word == WORD_RET) begin
                    result.op_class = CLS_RET;
                end else if ((instr_word & MASK_STACK) == PAT_POP) begin
                    result.op_class = CLS_POP;
                    result.dest_reg = rd5;
                end else if ((instr_word & MASK_STACK) == PAT_PUSH) begin
                    result.op_class = CLS_PUSH;
                    result.src_reg  = rd5;
                end else if ((instr_word & MASK_CALL) == PAT_CALL) begin
                    result.op_class   = CLS_CALL;
                    result.jump_field = next_word;
                end
            end
            GRP_RJMP: begin
                result.op_class   = CLS_RJMP;
                result.jump_field = {4'b0000, instr_word[11:0]};
            end
            GRP_LDI: begin
                result.op_class  = CLS_LDI;
                result.dest_reg  = rd_upper;
                result.imm_value = k8;
            end
            GRP_BRCH: begin
                if (instr_word[2:0] == BRANCH_TAIL) begin
                    if (instr_word[11:10] == SEL_BREQ) begin
                        result.op_class   = CLS_BREQ;
                        result.jump_field = {9'b0, instr_word[9:3]};
                    end else if (instr_word[11:10] == SEL_BRNE) begin
                        result.op_class   = CLS_BRNE;
                        result.jump_field = {9'b0, instr_word[9:3]};
                    end
                end
            end
            default: begin
                result = '0;
            end
        endcase
    end

endmodule

// File: rtl/core/avr_dec_out_stage.sv
module avr_dec_out_stage
    import avr_dec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  dec_result_t in_result,
    output logic        out_valid,
    input  logic        out_ready,
    output dec_result_t out_result
);

    logic        valid_reg;
    logic        valid_next;
    dec_result_t result_reg;

    // The stage refills in the same cycle that its word is taken.
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            result_reg <= in_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// File: rtl/core/avr_instruction_decoder_unit.sv
// Channel   Direction  tdata fields (low bit up)                          tuser/tlast
// s_        in         instr_word[15:0], next_word[31:16]                 none
// m_        out        op_class[3:0], dest_reg[8:4], src_reg[13:9],       none
//                      imm_value[21:14], jump_field[37:22], zero[39:38]
//
// One word is accepted every cycle while the result side keeps taking words.
// A word passes through an input register, the decode logic, then a result register.
// Both stages refill in the cycle their word moves on, so a stall holds both words
// and s_tready drops only when both stages are full.
// aresetn is synchronous and clears both valid flags; payload registers are not reset.
module avr_instruction_decoder_unit
    import avr_dec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // instr_word, next_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // op_class, dest_reg, src_reg, imm_value, jump_field
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [InstrWidth-1:0] instr_reg;
    logic [InstrWidth-1:0] next_word_reg;
    logic                  out_ready;
    dec_result_t           dec_result;
    dec_result_t           out_result;

    assign s_tready      = !in_valid_reg || out_ready;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            instr_reg     <= s_tdata[15:0];
            next_word_reg <= s_tdata[31:16];
        end
    end

    avr_dec_decode u_decode (
        .instr_word (instr_reg),
        .next_word  (next_word_reg),
        .result     (dec_result)
    );

    avr_dec_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (in_valid_reg),
        .in_ready   (out_ready),
        .in_result  (dec_result),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {2'b00, out_result};

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !in_valid_reg && !m_tvalid)
        else $error("pipeline not empty after reset");

    a_word_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_ready |=> m_tvalid)
        else $error("decoded word lost between stages");

    a_unknown_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_result.op_class == CLS_UNKNOWN |->
            out_result.dest_reg == '0 && out_result.src_reg == '0 &&
            out_result.imm_value == '0 && out_result.jump_field == '0)
        else $error("unknown class with nonzero operands");

    a_short_jump: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_result.op_class == CLS_RJMP ||
                     out_result.op_class == CLS_BREQ ||
                     out_result.op_class == CLS_BRNE) |->
            out_result.jump_field[15:12] == 4'b0000 && out_result.imm_value == '0)
        else $error("relative jump field out of range");

endmodule
